@@ design/dcb_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-sided crystal ball evaluator package
// Register indexes, reset values, region codes, pipeline stage types and the
// root constants used by the fractional power-of-two scaler.
// ----------------------------------------------------------------------------
package dcb_pkg;

   localparam logic [2:0] CSR_AMPLITUDE   = 3'd0;
   localparam logic [2:0] CSR_MEAN_OFFSET = 3'd1;
   localparam logic [2:0] CSR_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_LEFT_CUT    = 3'd3;
   localparam logic [2:0] CSR_LEFT_POWER  = 3'd4;
   localparam logic [2:0] CSR_RIGHT_CUT   = 3'd5;
   localparam logic [2:0] CSR_RIGHT_POWER = 3'd6;

   localparam logic [31:0] AMPLITUDE_RESET   = 32'd256;
   localparam logic [31:0] MEAN_OFFSET_RESET = 32'd0;
   localparam logic [30:0] WIDTH_RESET       = 31'd268435;
   localparam logic [15:0] CUT_RESET         = 16'd4096;
   localparam logic [14:0] POWER_RESET       = 15'd256;

   localparam logic [1:0] REGION_LEFT  = 2'd0;
   localparam logic [1:0] REGION_CORE  = 2'd1;
   localparam logic [1:0] REGION_RIGHT = 2'd2;

   localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
   localparam logic [30:0] ONE_Q30    = 31'd1073741824;
   localparam logic [46:0] U_MAX      = 47'h7FFF_FFFF_FFFF;
   localparam logic [14:0] POWER_MIN  = 15'd256;

   typedef struct packed {
      logic [1:0] region;
      logic       invalid;
   } tag_type;

   typedef struct packed {
      logic        neg;
      logic [30:0] rem;
      logic [48:0] quo;
   } div1_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [19:0] u;
      logic [46:0] t;
      logic [15:0] a;
   } cls_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [39:0] sq;
      logic [39:0] pa;
      logic [38:0] pb;
   } mul_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [53:0] hp;
      logic [62:0] at;
   } prd_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [23:0] e0;
      logic [14:0] rem;
      logic [62:0] quo;
   } div2_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [23:0] e0;
      logic [5:0]  sh;
      logic [63:0] v;
   } nrm_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] nn;
      logic [23:0] e0;
      logic [5:0]  pm;
      logic [30:0] m;
      logic [15:0] f;
   } log_type;

   typedef struct packed {
      tag_type     tag;
      logic [23:0] e0;
      logic [36:0] nl;
   } lgm_type;

   typedef struct packed {
      tag_type     tag;
      logic        zero;
      logic [5:0]  k;
      logic [15:0] f;
      logic [30:0] acc;
   } scl_type;

   typedef struct packed {
      tag_type     tag;
      logic        zero;
      logic [5:0]  k;
      logic [62:0] prod;
   } fin_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_v;
      rem   = x;
      root  = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bit_v) begin
            rem  = rem - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return root;
   endfunction

   function automatic logic [30:0] exp2_root(input int step);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int i = 1; i <= step; i++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

   localparam logic [30:0] EXP2_ROOT [16] = '{
      exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
      exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
      exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
      exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
   };

endpackage

@@ design/double_sided_crystal_ball_eval.sv @@
// ----------------------------------------------------------------------------
// Double-sided crystal ball evaluator
// Evaluates a Gaussian core with power-law tails on both sides for one sample
// per clock while the output is not stalled, in fixed point, through a deep pipeline.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the req_ stream and results leave on the rsp_
// stream, one result per sample and in order. A transfer takes place when
// tvalid and tready are both high. The csr_ port writes the shape registers
// and may only be used while no sample is in flight.
// Most of the pipeline is made up of the two restoring dividers (49 and 63
// stages, one quotient bit each), the 16 squaring stages of the logarithm and
// the 16 root multiplies of the power-of-two scaler. Throughput is one sample
// per cycle while the output is not stalled.
// The whole pipeline advances together; while a result waits in the output
// register and rsp_tready is low, every stage holds and req_tready is low.
// Reset clears all valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
module double_sided_crystal_ball_eval #(
   parameter int SAMPLE_FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value
   output logic [2:0]  rsp_tuser,   // invalid, region
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DIV1_STEPS  = 49;
   localparam int DIV2_STEPS  = 63;
   localparam int NORM_STEPS  = 6;
   localparam int LOG_STEPS   = 16;
   localparam int SCALE_STEPS = 16;
   localparam logic signed [33:0] MU_Q =
      34'(((64'd11157 << SAMPLE_FRAC_BITS) + 64'd5000) / 64'd10000);

   logic [31:0] amplitude_ff;
   logic [31:0] mean_offset_ff;
   logic [30:0] width_ff;
   logic [15:0] left_cut_ff;
   logic [14:0] left_power_ff;
   logic [15:0] right_cut_ff;
   logic [14:0] right_power_ff;

   logic adv;

   logic             d1_valid_ff [0:DIV1_STEPS];
   logic             d1_valid_in [0:DIV1_STEPS];
   dcb_pkg::div1_type d1_ff [0:DIV1_STEPS];
   dcb_pkg::div1_type d1_in [0:DIV1_STEPS];

   logic             cls_valid_ff;
   dcb_pkg::cls_type cls_ff;
   dcb_pkg::cls_type cls_in;
   logic             mul_valid_ff;
   dcb_pkg::mul_type mul_ff;
   dcb_pkg::mul_type mul_in;
   logic             prd_valid_ff;
   dcb_pkg::prd_type prd_ff;
   dcb_pkg::prd_type prd_in;

   logic              d2_valid_ff [0:DIV2_STEPS];
   logic              d2_valid_in [0:DIV2_STEPS];
   dcb_pkg::div2_type d2_ff [0:DIV2_STEPS];
   dcb_pkg::div2_type d2_in [0:DIV2_STEPS];

   logic             nrm_valid_ff [0:NORM_STEPS];
   logic             nrm_valid_in [0:NORM_STEPS];
   dcb_pkg::nrm_type nrm_ff [0:NORM_STEPS];
   dcb_pkg::nrm_type nrm_in [0:NORM_STEPS];

   logic             lg_valid_ff [0:LOG_STEPS];
   logic             lg_valid_in [0:LOG_STEPS];
   dcb_pkg::log_type lg_ff [0:LOG_STEPS];
   dcb_pkg::log_type lg_in [0:LOG_STEPS];

   logic             lgm_valid_ff;
   dcb_pkg::lgm_type lgm_ff;
   dcb_pkg::lgm_type lgm_in;

   logic             sc_valid_ff [0:SCALE_STEPS];
   logic             sc_valid_in [0:SCALE_STEPS];
   dcb_pkg::scl_type sc_ff [0:SCALE_STEPS];
   dcb_pkg::scl_type sc_in [0:SCALE_STEPS];

   logic             fin_valid_ff;
   dcb_pkg::fin_type fin_ff;
   dcb_pkg::fin_type fin_in;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_value_ff;
   logic [31:0]      rsp_value_in;
   dcb_pkg::tag_type rsp_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff   <= dcb_pkg::AMPLITUDE_RESET;
         mean_offset_ff <= dcb_pkg::MEAN_OFFSET_RESET;
         width_ff       <= dcb_pkg::WIDTH_RESET;
         left_cut_ff    <= dcb_pkg::CUT_RESET;
         left_power_ff  <= dcb_pkg::POWER_RESET;
         right_cut_ff   <= dcb_pkg::CUT_RESET;
         right_power_ff <= dcb_pkg::POWER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dcb_pkg::CSR_AMPLITUDE: begin
               amplitude_ff <= csr_wdata;
            end
            dcb_pkg::CSR_MEAN_OFFSET: begin
               mean_offset_ff <= csr_wdata;
            end
            dcb_pkg::CSR_WIDTH: begin
               width_ff <= csr_wdata[30:0];
            end
            dcb_pkg::CSR_LEFT_CUT: begin
               left_cut_ff <= csr_wdata[15:0];
            end
            dcb_pkg::CSR_LEFT_POWER: begin
               left_power_ff <= csr_wdata[14:0];
            end
            dcb_pkg::CSR_RIGHT_CUT: begin
               right_cut_ff <= csr_wdata[15:0];
            end
            dcb_pkg::CSR_RIGHT_POWER: begin
               right_power_ff <= csr_wdata[14:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Offset subtraction and the first divider: u = |d| * 2^16 / width.
   always_comb begin
      logic signed [33:0] diff;
      logic [32:0]        mag;
      logic [31:0]        trial;
      logic               ge;
      diff  = 34'(signed'(req_tdata)) - MU_Q - 34'(signed'(mean_offset_ff));
      mag   = diff[33] ? 33'(-diff) : 33'(diff);
      d1_valid_in[0] = req_tvalid;
      d1_in[0].neg   = diff[33];
      d1_in[0].rem   = '0;
      d1_in[0].quo   = {mag, 16'd0};
      for (int i = 1; i <= DIV1_STEPS; i++) begin
         trial = {d1_ff[i-1].rem, d1_ff[i-1].quo[48]};
         ge    = trial >= {1'b0, width_ff};
         d1_valid_in[i] = d1_valid_ff[i-1];
         d1_in[i].neg   = d1_ff[i-1].neg;
         d1_in[i].rem   = ge ? 31'(trial - {1'b0, width_ff}) : trial[30:0];
         d1_in[i].quo   = {d1_ff[i-1].quo[47:0], ge};
      end
   end

   // Region selection.
   always_comb begin
      logic [48:0] quo;
      logic [46:0] u;
      logic [46:0] a1;
      logic [46:0] a2;
      logic        left;
      logic        right;
      logic [14:0] pw;
      quo   = d1_ff[DIV1_STEPS].quo;
      u     = (|quo[48:47]) ? dcb_pkg::U_MAX : quo[46:0];
      a1    = 47'({left_cut_ff, 4'd0});
      a2    = 47'({right_cut_ff, 4'd0});
      left  = d1_ff[DIV1_STEPS].neg && (u > a1);
      right = !d1_ff[DIV1_STEPS].neg && (u >= a2);
      pw    = left ? left_power_ff : right_power_ff;
      cls_in.nn = (pw < dcb_pkg::POWER_MIN) ? dcb_pkg::POWER_MIN : pw;
      cls_in.u  = u[19:0];
      cls_in.t  = '0;
      cls_in.a  = '0;
      if (width_ff == 31'd0) begin
         cls_in.tag.region  = dcb_pkg::REGION_CORE;
         cls_in.tag.invalid = 1'b1;
      end else if (left) begin
         cls_in.tag.region  = dcb_pkg::REGION_LEFT;
         cls_in.tag.invalid = left_cut_ff == 16'd0;
         cls_in.a           = left_cut_ff;
         cls_in.t           = u - a1;
      end else if (right) begin
         cls_in.tag.region  = dcb_pkg::REGION_RIGHT;
         cls_in.tag.invalid = right_cut_ff == 16'd0;
         cls_in.a           = right_cut_ff;
         cls_in.t           = u - a2;
      end else begin
         cls_in.tag.region  = dcb_pkg::REGION_CORE;
         cls_in.tag.invalid = 1'b0;
      end
   end

   // Squares and the partial products of a * t.
   always_comb begin
      logic [19:0] op;
      op = (cls_ff.tag.region == dcb_pkg::REGION_CORE) ? cls_ff.u : {4'd0, cls_ff.a};
      mul_in.tag = cls_ff.tag;
      mul_in.nn  = cls_ff.nn;
      mul_in.sq  = 40'(op) * 40'(op);
      mul_in.pa  = 40'(cls_ff.a) * 40'(cls_ff.t[23:0]);
      mul_in.pb  = 39'(cls_ff.a) * 39'(cls_ff.t[46:24]);
   end

   always_comb begin
      logic [22:0] h;
      if (mul_ff.tag.region == dcb_pkg::REGION_CORE) begin
         h = 23'((mul_ff.sq + 40'd65536) >> 17);
      end else begin
         h = 23'((mul_ff.sq + 40'd256) >> 9);
      end
      prd_in.tag = mul_ff.tag;
      prd_in.nn  = mul_ff.nn;
      prd_in.hp  = 54'(h) * 54'(dcb_pkg::LOG2E_Q30);
      prd_in.at  = 63'(mul_ff.pa) + (63'(mul_ff.pb) << 24);
   end

   // Second divider: r = a * t / n.
   always_comb begin
      logic [15:0] trial;
      logic        ge;
      d2_valid_in[0] = prd_valid_ff;
      d2_in[0].tag   = prd_ff.tag;
      d2_in[0].nn    = prd_ff.nn;
      d2_in[0].e0    = 24'((prd_ff.hp + 54'd536870912) >> 30);
      d2_in[0].rem   = '0;
      d2_in[0].quo   = prd_ff.at;
      for (int i = 1; i <= DIV2_STEPS; i++) begin
         trial = {d2_ff[i-1].rem, d2_ff[i-1].quo[62]};
         ge    = trial >= {1'b0, d2_ff[i-1].nn};
         d2_valid_in[i] = d2_valid_ff[i-1];
         d2_in[i].tag   = d2_ff[i-1].tag;
         d2_in[i].nn    = d2_ff[i-1].nn;
         d2_in[i].e0    = d2_ff[i-1].e0;
         d2_in[i].rem   = ge ? 15'(trial - {1'b0, d2_ff[i-1].nn}) : trial[14:0];
         d2_in[i].quo   = {d2_ff[i-1].quo[61:0], ge};
      end
   end

   // Leading-one search on 2^20 + r.
   always_comb begin
      int amt;
      nrm_valid_in[0] = d2_valid_ff[DIV2_STEPS];
      nrm_in[0].tag   = d2_ff[DIV2_STEPS].tag;
      nrm_in[0].nn    = d2_ff[DIV2_STEPS].nn;
      nrm_in[0].e0    = d2_ff[DIV2_STEPS].e0;
      nrm_in[0].sh    = '0;
      nrm_in[0].v     = {1'b0, d2_ff[DIV2_STEPS].quo} + 64'd1048576;
      for (int i = 1; i <= NORM_STEPS; i++) begin
         amt = 32 >> (i - 1);
         nrm_valid_in[i] = nrm_valid_ff[i-1];
         nrm_in[i]       = nrm_ff[i-1];
         if ((nrm_ff[i-1].v >> (64 - amt)) == 64'd0) begin
            nrm_in[i].v  = nrm_ff[i-1].v << amt;
            nrm_in[i].sh = nrm_ff[i-1].sh + 6'(amt);
         end
      end
   end

   // Fraction bits of the logarithm by repeated squaring.
   always_comb begin
      logic [61:0] sqm;
      logic [31:0] mm;
      lg_valid_in[0] = nrm_valid_ff[NORM_STEPS];
      lg_in[0].tag   = nrm_ff[NORM_STEPS].tag;
      lg_in[0].nn    = nrm_ff[NORM_STEPS].nn;
      lg_in[0].e0    = nrm_ff[NORM_STEPS].e0;
      lg_in[0].pm    = 6'd43 - nrm_ff[NORM_STEPS].sh;
      lg_in[0].m     = nrm_ff[NORM_STEPS].v[63:33];
      lg_in[0].f     = '0;
      for (int i = 1; i <= LOG_STEPS; i++) begin
         sqm = 62'(lg_ff[i-1].m) * 62'(lg_ff[i-1].m);
         mm  = 32'(sqm >> 30);
         lg_valid_in[i] = lg_valid_ff[i-1];
         lg_in[i].tag   = lg_ff[i-1].tag;
         lg_in[i].nn    = lg_ff[i-1].nn;
         lg_in[i].e0    = lg_ff[i-1].e0;
         lg_in[i].pm    = lg_ff[i-1].pm;
         lg_in[i].m     = mm[31] ? mm[31:1] : mm[30:0];
         lg_in[i].f     = {lg_ff[i-1].f[14:0], mm[31]};
      end
   end

   always_comb begin
      lgm_in.tag = lg_ff[LOG_STEPS].tag;
      lgm_in.e0  = lg_ff[LOG_STEPS].e0;
      lgm_in.nl  = 37'(lg_ff[LOG_STEPS].nn) *
                   37'({lg_ff[LOG_STEPS].pm, lg_ff[LOG_STEPS].f});
   end

   // Exponent assembly and the 2^-f scaler.
   always_comb begin
      logic [29:0] e;
      logic [61:0] pr;
      if (lgm_ff.tag.region == dcb_pkg::REGION_CORE) begin
         e = 30'(lgm_ff.e0);
      end else begin
         e = 30'(lgm_ff.e0) + 30'((lgm_ff.nl + 37'd128) >> 8);
      end
      sc_valid_in[0] = lgm_valid_ff;
      sc_in[0].tag   = lgm_ff.tag;
      sc_in[0].zero  = lgm_ff.tag.invalid || (e[29:16] > 14'd32);
      sc_in[0].k     = e[21:16];
      sc_in[0].f     = e[15:0];
      sc_in[0].acc   = dcb_pkg::ONE_Q30;
      for (int i = 1; i <= SCALE_STEPS; i++) begin
         pr = 62'(sc_ff[i-1].acc) * 62'(dcb_pkg::EXP2_ROOT[i-1]);
         sc_valid_in[i] = sc_valid_ff[i-1];
         sc_in[i]       = sc_ff[i-1];
         if (sc_ff[i-1].f[16-i]) begin
            sc_in[i].acc = 31'((pr + 62'd536870912) >> 30);
         end
      end
   end

   always_comb begin
      fin_in.tag  = sc_ff[SCALE_STEPS].tag;
      fin_in.zero = sc_ff[SCALE_STEPS].zero;
      fin_in.k    = sc_ff[SCALE_STEPS].k;
      fin_in.prod = 63'(amplitude_ff) * 63'(sc_ff[SCALE_STEPS].acc);
   end

   always_comb begin
      logic [6:0]  s;
      logic [62:0] q;
      s = 7'd29 + 7'(fin_ff.k);
      q = ((fin_ff.prod >> s) + 63'd1) >> 1;
      rsp_value_in = fin_ff.zero ? 32'd0 : q[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV1_STEPS; i++) begin
            d1_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= DIV2_STEPS; i++) begin
            d2_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= NORM_STEPS; i++) begin
            nrm_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= LOG_STEPS; i++) begin
            lg_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= SCALE_STEPS; i++) begin
            sc_valid_ff[i] <= 1'b0;
         end
         cls_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         prd_valid_ff <= 1'b0;
         lgm_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i <= DIV1_STEPS; i++) begin
            d1_valid_ff[i] <= d1_valid_in[i];
         end
         for (int i = 0; i <= DIV2_STEPS; i++) begin
            d2_valid_ff[i] <= d2_valid_in[i];
         end
         for (int i = 0; i <= NORM_STEPS; i++) begin
            nrm_valid_ff[i] <= nrm_valid_in[i];
         end
         for (int i = 0; i <= LOG_STEPS; i++) begin
            lg_valid_ff[i] <= lg_valid_in[i];
         end
         for (int i = 0; i <= SCALE_STEPS; i++) begin
            sc_valid_ff[i] <= sc_valid_in[i];
         end
         cls_valid_ff <= d1_valid_ff[DIV1_STEPS];
         mul_valid_ff <= cls_valid_ff;
         prd_valid_ff <= mul_valid_ff;
         lgm_valid_ff <= lg_valid_ff[LOG_STEPS];
         fin_valid_ff <= sc_valid_ff[SCALE_STEPS];
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= DIV1_STEPS; i++) begin
            d1_ff[i] <= d1_in[i];
         end
         for (int i = 0; i <= DIV2_STEPS; i++) begin
            d2_ff[i] <= d2_in[i];
         end
         for (int i = 0; i <= NORM_STEPS; i++) begin
            nrm_ff[i] <= nrm_in[i];
         end
         for (int i = 0; i <= LOG_STEPS; i++) begin
            lg_ff[i] <= lg_in[i];
         end
         for (int i = 0; i <= SCALE_STEPS; i++) begin
            sc_ff[i] <= sc_in[i];
         end
         cls_ff       <= cls_in;
         mul_ff       <= mul_in;
         prd_ff       <= prd_in;
         lgm_ff       <= lgm_in;
         fin_ff       <= fin_in;
         rsp_value_ff <= rsp_value_in;
         rsp_tag_ff   <= fin_ff.tag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_tag_ff.invalid, rsp_tag_ff.region};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 32'd0)
      else $error("Invalid result carries a nonzero value.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= amplitude_ff)
      else $error("Result exceeds the amplitude.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input accepted while the output is stalled.");

endmodule

@@ tb/double_sided_crystal_ball_eval_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-sided crystal ball evaluator testbench
// Sends samples over the request stream under several register settings and
// compares every response, field by field, with a fixed-point prediction of
// the Gaussian core and both power-law tails computed in the testbench.
// ----------------------------------------------------------------------------
module double_sided_crystal_ball_eval_tb;

   localparam int FRAC = 28;
   localparam longint unsigned CENTER = ((64'd11157 << FRAC) + 64'd5000) / 64'd10000;
   localparam longint LIMIT = 1500000;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  region;
      logic        invalid;
   } result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic [31:0] amp_r;
   logic [31:0] mean_r;
   logic [30:0] width_r;
   logic [15:0] lcut_r, rcut_r;
   logic [14:0] lpow_r, rpow_r;

   result_type pending_results[$];
   int      mismatches = 0;
   longint  cycles = 0;
   bit      calm = 0;
   bit      hold_rsp = 0;
   longint unsigned roots[1:16];

   double_sided_crystal_ball_eval dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned log2_fixed(longint unsigned v);
      int p = 63;
      longint unsigned m, f = 0;
      while (p > 0 && v[p] == 0) p--;
      m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         f <<= 1;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            f |= 1;
         end
      end
      return (longint'(p) << 16) | f;
   endfunction

   function automatic longint unsigned weight_log2e(longint unsigned h);
      return (h * 64'd1549082005 + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint unsigned scale_pow2(longint unsigned e);
      longint unsigned k = e >> 16, f = e & 16'hFFFF, acc = 64'd1 << 30;
      int s;
      if (k > 32) return 0;
      for (int i = 1; i <= 16; i++)
         if ((f >> (16 - i)) & 1) acc = (acc * roots[i] + (64'd1 << 29)) >> 30;
      s = 30 + int'(k);
      return (longint'(amp_r) * acc + (64'd1 << (s - 1))) >> s;
   endfunction

   function automatic longint unsigned tail_exp(longint unsigned a, longint unsigned n,
                                               longint unsigned t);
      longint unsigned h = (a * a + 256) >> 9, r, l;
      if (n < 256) n = 256;
      r = (a * t) / n;
      l = log2_fixed((64'd1 << 20) + r) - (64'd20 << 16);
      return weight_log2e(h) + ((n * l + 128) >> 8);
   endfunction

   function automatic result_type predict_shape(logic [31:0] x);
      result_type res;
      longint d, a1, a2;
      longint unsigned mag, u, h;
      d = longint'($signed(x)) - longint'(CENTER) - longint'($signed(mean_r));
      a1 = longint'(lcut_r) << 4;
      a2 = longint'(rcut_r) << 4;
      res = '{value: 0, region: dcb_pkg::REGION_CORE, invalid: 0};
      if (width_r == 0) begin
         res.invalid = 1;
      end else begin
         mag = (d < 0) ? -d : d;
         u = (mag << 16) / width_r;
         if (u > 64'h7FFF_FFFF_FFFF) u = 64'h7FFF_FFFF_FFFF;
         if (d < 0 && u > a1) begin
            res.region = dcb_pkg::REGION_LEFT;
            if (lcut_r == 0) res.invalid = 1;
            else res.value = 32'(scale_pow2(tail_exp(lcut_r, lpow_r, u - a1)));
         end else if (d >= 0 && u >= a2) begin
            res.region = dcb_pkg::REGION_RIGHT;
            if (rcut_r == 0) res.invalid = 1;
            else res.value = 32'(scale_pow2(tail_exp(rcut_r, rpow_r, u - a2)));
         end else begin
            h = (u * u + (64'd1 << 16)) >> 17;
            res.value = 32'(scale_pow2(weight_log2e(h)));
         end
      end
      return res;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         dcb_pkg::CSR_AMPLITUDE:   amp_r = data;
         dcb_pkg::CSR_MEAN_OFFSET: mean_r = data;
         dcb_pkg::CSR_WIDTH:       width_r = data[30:0];
         dcb_pkg::CSR_LEFT_CUT:    lcut_r = data[15:0];
         dcb_pkg::CSR_LEFT_POWER:  lpow_r = data[14:0];
         dcb_pkg::CSR_RIGHT_CUT:   rcut_r = data[15:0];
         dcb_pkg::CSR_RIGHT_POWER: rpow_r = data[14:0];
         default: begin
         end
      endcase
   endtask

   task automatic send_sample(logic [31:0] x);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= x;
      pending_results = {pending_results, predict_shape(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_tready <= !hold_rsp && (calm || $urandom_range(99) >= 15);

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{value: rsp_tdata, region: rsp_tuser[1:0], invalid: rsp_tuser[2]};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %h %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp value %h region %0d invalid %0d, got %h %0d %0d",
                           want.value, want.region, want.invalid,
                           got.value, got.region, got.invalid);
            end
         end
      end
   end

   function automatic logic [31:0] near_center();
      return 32'(CENTER) + $signed(mean_r) + 32'($signed($urandom_range(8000000)) - 4000000);
   endfunction

   task automatic test_directed();
      logic [31:0] edge_vals[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                    32'(CENTER), 32'(CENTER) + 32'd268435};
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      send_sample(32'(CENTER) - 32'd268436);
      send_sample(32'(CENTER) - 32'd300000);
      send_sample(32'(CENTER) + 32'd300000);
      drain();
      write_reg(dcb_pkg::CSR_WIDTH, 0);
      send_sample(32'(CENTER));
      send_sample(32'h1234_5678);
      drain();
      write_reg(dcb_pkg::CSR_WIDTH, 32'd268435);
      write_reg(dcb_pkg::CSR_LEFT_CUT, 0);
      write_reg(dcb_pkg::CSR_RIGHT_CUT, 0);
      send_sample(32'(CENTER) - 32'd1000);
      send_sample(32'(CENTER) + 32'd1000);
      send_sample(32'(CENTER));
      drain();
      write_reg(dcb_pkg::CSR_LEFT_POWER, 32'd100);
      write_reg(dcb_pkg::CSR_RIGHT_POWER, 32'h7FFF);
      write_reg(dcb_pkg::CSR_LEFT_CUT, 32'hFFFF);
      write_reg(dcb_pkg::CSR_RIGHT_CUT, 32'd1);
      write_reg(dcb_pkg::CSR_AMPLITUDE, 32'hFFFF_FFFF);
      write_reg(dcb_pkg::CSR_MEAN_OFFSET, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'(CENTER) + 32'h8000_0000);
      drain();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 12; phase++) begin
         write_reg(dcb_pkg::CSR_AMPLITUDE, (phase % 4 == 0) ? 32'hFFFF_FFFF : $urandom);
         write_reg(dcb_pkg::CSR_MEAN_OFFSET, (phase % 3 == 0) ? 32'h0 : $urandom);
         write_reg(dcb_pkg::CSR_WIDTH, (phase == 5) ? 32'h7FFF_FFFF :
                   (phase == 6) ? 32'd1 : $urandom_range(1 << 29, 1000));
         write_reg(dcb_pkg::CSR_LEFT_CUT,
                   (phase == 7) ? 32'd40960 : $urandom_range(40960, 0));
         write_reg(dcb_pkg::CSR_RIGHT_CUT,
                   (phase == 8) ? 32'hFFFF : $urandom_range(40960, 0));
         write_reg(dcb_pkg::CSR_LEFT_POWER,
                   (phase == 9) ? 32'd25600 : $urandom_range(32767, 0));
         write_reg(dcb_pkg::CSR_RIGHT_POWER,
                   (phase == 10) ? 32'd256 : $urandom_range(25600, 200));
         calm = (phase == 3);
         for (int i = 0; i < 135; i++)
            send_sample(($urandom_range(3) == 0) ? $urandom : near_center());
         drain();
         calm = 0;
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 300; i++) send_sample(near_center());
      join
      drain();
   endtask

   initial begin
      amp_r = dcb_pkg::AMPLITUDE_RESET;
      mean_r = dcb_pkg::MEAN_OFFSET_RESET;
      width_r = dcb_pkg::WIDTH_RESET;
      lcut_r = dcb_pkg::CUT_RESET;
      rcut_r = dcb_pkg::CUT_RESET;
      lpow_r = dcb_pkg::POWER_RESET;
      rpow_r = dcb_pkg::POWER_RESET;
      roots[1] = int_sqrt((64'd1 << 29) << 30);
      for (int i = 2; i <= 16; i++) roots[i] = int_sqrt(roots[i - 1] << 30);
      repeat (6) @(negedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random_settings();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
